// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: rtl/stb_pkg.sv
package stb_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_W     = 4;
    localparam int TICK_W     = 32;
    localparam int STEP_W     = 10;
    localparam int ACTION_W   = 3;
    localparam int KIND_W     = 2;

    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 8;
    localparam int DELAY_LSB  = SLOT_W;
    localparam int RELOAD_LSB = SLOT_W + TICK_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1);
    localparam logic REG_SEL_STEP = 1'b0;

    typedef enum logic [ACTION_W-1:0] {
        ACT_REGISTER = 3'd0,
        ACT_SET      = 3'd1,
        ACT_START    = 3'd2,
        ACT_STOP     = 3'd3,
        ACT_UNREG    = 3'd4,
        ACT_TICK     = 3'd5,
        ACT_SCAN     = 3'd6
    } action_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_EXPIRY   = 2'd0,
        KIND_SET_OK   = 2'd1,
        KIND_SET_FAIL = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SET_PUSH,
        ST_SCAN_EVAL,
        ST_SCAN_END
    } state_t;

    typedef struct packed {
        logic item_load;
        logic simple_exec;
        logic set_push;
        logic scan_start;
        logic scan_step;
        logic end_push;
    } stb_cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                at_last;
        logic                stall;
        logic                held_valid;
        logic                out_free;
    } stb_sts_t;

endpackage

// File: rtl/stb_ctrl.sv
`include "assert_macros.svh"

module stb_ctrl
    import stb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  stb_sts_t sts,
    output stb_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (sts.action)
                    ACT_SET:  state_next = ST_SET_PUSH;
                    ACT_SCAN: state_next = ST_SCAN_EVAL;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_SET_PUSH: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_EVAL: begin
                if (!sts.stall && sts.at_last) begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                if (!sts.held_valid || sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready      = aresetn;
                cmd.item_load = s_tvalid && aresetn;
            end
            ST_EXEC: begin
                unique case (sts.action)
                    ACT_SET:  cmd.simple_exec = 1'b0;
                    ACT_SCAN: cmd.scan_start  = 1'b1;
                    default:  cmd.simple_exec = 1'b1;
                endcase
            end
            ST_SET_PUSH:  cmd.set_push  = sts.out_free;
            ST_SCAN_EVAL: cmd.scan_step = !sts.stall;
            ST_SCAN_END:  cmd.end_push  = sts.held_valid && sts.out_free;
            default: ;
        endcase
    end

    `ASSERT_PROP(a_push_free, aclk, aresetn,
        (cmd.set_push || cmd.end_push) |-> sts.out_free, "push while output busy")
    `ASSERT_PROP(a_step_nostall, aclk, aresetn,
        cmd.scan_step |-> !sts.stall, "scan step taken while stalled")
    `ASSERT_PROP(a_end_idle, aclk, aresetn,
        (state_reg == ST_SCAN_END && !sts.held_valid) |=> state_reg == ST_IDLE,
        "scan end did not return to idle")

endmodule

// File: rtl/stb_dp.sv
`include "assert_macros.svh"

module stb_dp
    import stb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  stb_cmd_t             cmd,
    output stb_sts_t             sts,
    input  logic [STEP_W-1:0]    tick_step,
    input  logic [ACTION_W-1:0]  in_action,
    input  logic [SLOT_W-1:0]    in_slot,
    input  logic [TICK_W-1:0]    in_delay,
    input  logic [TICK_W-1:0]    in_reload,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [SLOT_W-1:0]    m_slot,
    output logic [KIND_W-1:0]    m_kind,
    output logic                 m_last
);

    // input item
    logic [ACTION_W-1:0] act_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [TICK_W-1:0]   delay_reg;
    logic [TICK_W-1:0]   reload_reg;

    logic [TICK_W-1:0]    tick_now_reg, tick_now_next;
    logic [NUM_SLOTS-1:0] regd_reg, regd_next;
    logic [NUM_SLOTS-1:0] en_reg, en_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 held_valid_reg, held_valid_next;
    logic [IDX_W-1:0]     held_slot_reg, held_slot_next;

    logic                 m_valid_reg;
    logic [SLOT_W-1:0]    m_slot_reg;
    logic [KIND_W-1:0]    m_kind_reg;
    logic                 m_last_reg;

    // slot tables
    logic [TICK_W-1:0] st_mem [NUM_SLOTS];
    logic [TICK_W-1:0] cd_mem [NUM_SLOTS];
    logic [TICK_W-1:0] rl_mem [NUM_SLOTS];
    logic [TICK_W-1:0] st_q, cd_q, rl_q;

    logic [IDX_W-1:0]  sidx;
    logic              in_range;
    logic              set_ok;
    logic              active, due, emit, out_free;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr, wr_idx;
    logic              st_we, cd_we, rl_we;
    logic [TICK_W-1:0] cd_wdata;
    logic              push_out;

    assign sidx     = IDX_W'(slot_reg);
    assign in_range = 32'(slot_reg) < NUM_SLOTS;
    assign set_ok   = in_range && regd_reg[sidx];
    assign out_free = !m_valid_reg || m_tready;

    assign active = regd_reg[idx_reg] && en_reg[idx_reg];
    assign due    = active && ((tick_now_reg - st_q) >= cd_q);
    assign emit   = due && (cd_q != '0);

    assign sts.action     = act_reg;
    assign sts.at_last    = idx_reg == IDX_W'(NUM_SLOTS - 1);
    assign sts.stall      = emit && held_valid_reg && !out_free;
    assign sts.held_valid = held_valid_reg;
    assign sts.out_free   = out_free;

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            act_reg    <= in_action;
            slot_reg   <= in_slot;
            delay_reg  <= in_delay;
            reload_reg <= in_reload;
        end
    end

    // state update
    always_comb begin
        tick_now_next   = tick_now_reg;
        regd_next       = regd_reg;
        en_next         = en_reg;
        idx_next        = idx_reg;
        held_valid_next = held_valid_reg;
        held_slot_next  = held_slot_reg;
        if (cmd.simple_exec) begin
            case (act_reg)
                ACT_REGISTER: begin
                    if (in_range && !regd_reg[sidx]) begin
                        regd_next[sidx] = 1'b1;
                        en_next[sidx]   = 1'b0;
                    end
                end
                ACT_START: begin
                    if (in_range) begin
                        en_next[sidx] = 1'b1;
                    end
                end
                ACT_STOP: begin
                    if (in_range) begin
                        en_next[sidx] = 1'b0;
                    end
                end
                ACT_UNREG: begin
                    if (in_range) begin
                        regd_next[sidx] = 1'b0;
                    end
                end
                ACT_TICK: tick_now_next = tick_now_reg + TICK_W'(tick_step);
                default: ;
            endcase
        end
        if (cmd.scan_start) begin
            idx_next        = '0;
            held_valid_next = 1'b0;
        end
        if (cmd.scan_step) begin
            if (due && rl_q == '0) begin
                en_next[idx_reg] = 1'b0;
            end
            if (emit) begin
                held_valid_next = 1'b1;
                held_slot_next  = idx_reg;
            end
            if (!sts.at_last) begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
        if (cmd.end_push) begin
            held_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_now_reg   <= '0;
            regd_reg       <= '0;
            en_reg         <= '0;
            idx_reg        <= '0;
            held_valid_reg <= 1'b0;
        end else begin
            tick_now_reg   <= tick_now_next;
            regd_reg       <= regd_next;
            en_reg         <= en_next;
            idx_reg        <= idx_next;
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_slot_reg <= held_slot_next;
    end

    // table access
    assign rd_en    = cmd.scan_start || (cmd.scan_step && !sts.at_last);
    assign rd_addr  = cmd.scan_start ? '0 : idx_reg + IDX_W'(1);
    assign wr_idx   = cmd.scan_step ? idx_reg : sidx;
    assign st_we    = (cmd.simple_exec && act_reg == ACT_REGISTER && in_range)
                    || (cmd.scan_step && due && rl_q != '0);
    assign cd_we    = (cmd.set_push && set_ok) || (cmd.scan_step && due && rl_q != '0);
    assign rl_we    = cmd.set_push && set_ok;
    assign cd_wdata = cmd.scan_step ? rl_q : delay_reg;

    always_ff @(posedge aclk) begin
        if (st_we) begin
            st_mem[wr_idx] <= tick_now_reg;
        end
        if (cd_we) begin
            cd_mem[wr_idx] <= cd_wdata;
        end
        if (rl_we) begin
            rl_mem[wr_idx] <= reload_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            st_q <= st_mem[rd_addr];
            cd_q <= cd_mem[rd_addr];
            rl_q <= rl_mem[rd_addr];
        end
    end

    // result register
    assign push_out = cmd.set_push || cmd.end_push
                    || (cmd.scan_step && emit && held_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_out) begin
            m_slot_reg <= cmd.set_push ? slot_reg : SLOT_W'(held_slot_reg);
            m_kind_reg <= cmd.set_push ? (set_ok ? KIND_SET_OK : KIND_SET_FAIL)
                                       : KIND_EXPIRY;
            m_last_reg <= cmd.set_push || cmd.end_push;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_slot   = m_slot_reg;
    assign m_kind   = m_kind_reg;
    assign m_last   = m_last_reg;

    `ASSERT_PROP(a_set_last, aclk, aresetn,
        (m_valid_reg && m_kind_reg != KIND_EXPIRY) |-> m_last_reg,
        "set result without last")
    `ASSERT_PROP(a_no_overwrite, aclk, aresetn,
        push_out |-> out_free, "waiting result overwritten")
    `ASSERT_PROP(a_held_order, aclk, aresetn,
        (cmd.scan_step && held_valid_reg) |-> held_slot_reg < idx_reg,
        "held expiry not from an earlier slot")

endmodule

// File: rtl/soft_timer_bank.sv
// Bank of NUM_SLOTS timer slots sharing a 32-bit tick counter, moved by ticks only. Each input
// transaction carries an action in s_tuser: register, set values, start, stop, unregister,
// tick (adds tick_step, APB register at offset 0, reset 1) or scan. Set values always
// returns one result (ok or unregistered). A scan walks the slots in index order and returns
// one expiry result per due slot with a nonzero delay, the final one flagged with tlast; a scan
// with nothing due returns nothing. The block takes one transaction at a time. A scan reads
// the slot tables through their single read port, one slot per cycle unless the result side
// stalls.
`include "assert_macros.svh"

module soft_timer_bank
    import stb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // apb
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // slot, first_delay, reload_interval, zero pad
    input  logic [ACTION_W-1:0]   s_tuser,   // action
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // slot_out, zero pad
    output logic [KIND_W-1:0]     m_tuser,   // kind
    output logic                  m_tlast
);

    logic [STEP_W-1:0] tick_step_reg;
    logic              cfg_wr;
    stb_cmd_t          cmd;
    stb_sts_t          sts;
    logic [SLOT_W-1:0] m_slot;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_step_reg <= STEP_RESET;
        end else if (cfg_wr && paddr[APB_ADDR_W-1] == REG_SEL_STEP) begin
            tick_step_reg <= pwdata[STEP_W-1:0];
        end
    end

    assign prdata = (paddr[APB_ADDR_W-1] == REG_SEL_STEP) ? APB_DATA_W'(tick_step_reg) : '0;

    stb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    stb_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .tick_step (tick_step_reg),
        .in_action (s_tuser),
        .in_slot   (s_tdata[SLOT_W-1:0]),
        .in_delay  (s_tdata[DELAY_LSB +: TICK_W]),
        .in_reload (s_tdata[RELOAD_LSB +: TICK_W]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_slot    (m_slot),
        .m_kind    (m_tuser),
        .m_last    (m_tlast)
    );

    assign m_tdata = M_TDATA_W'(m_slot);

    `ASSERT_PROP(a_cfg_idle, aclk, aresetn,
        (cfg_wr && paddr[APB_ADDR_W-1] == REG_SEL_STEP) |-> s_tready,
        "tick_step written while busy")
    `ASSERT_ALWAYS(a_ready_ack, aclk, pready, "pready low")
    `ASSERT_PROP(a_accept_busy, aclk, aresetn,
        (s_tvalid && s_tready) |=> !s_tready, "second transaction taken while busy")

endmodule

// File: tb/soft_timer_bank_tb.sv
`timescale 1ns / 100ps

module soft_timer_bank_tb;
    import stb_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int HOLD_CYCLES    = 1500;
    localparam int DRAIN_CYCLES   = NUM_SLOTS + 8;
    localparam int MAX_REPORTS    = 10;
    localparam int MAX_EXPIRIES   = 16;

    localparam logic [APB_ADDR_W-1:0] ADDR_TICK_STEP = '0;
    localparam logic [ACTION_W-1:0]   ACT_UNDEFINED  = 3'd7;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        kind_t             kind;
        logic              last;
    } timer_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // slot, first_delay, reload_interval, zero pad
    logic [ACTION_W-1:0]   s_tuser;   // action
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // slot_out, zero pad
    logic [KIND_W-1:0]     m_tuser;   // kind
    logic                  m_tlast;

    // predicted bank state
    logic [STEP_W-1:0] step_now;
    logic [TICK_W-1:0] tick_now;
    bit                slot_registered [NUM_SLOTS];
    bit                slot_enabled    [NUM_SLOTS];
    bit                values_written  [NUM_SLOTS];
    logic [TICK_W-1:0] slot_start      [NUM_SLOTS];
    logic [TICK_W-1:0] slot_delay      [NUM_SLOTS];
    logic [TICK_W-1:0] slot_reload     [NUM_SLOTS];

    timer_result_t awaited_results[$];

    int error_count        = 0;
    int sent_count         = 0;
    int result_count       = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_cycles        = 0;

    soft_timer_bank dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic void flag_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void apply_timer_action(input logic [ACTION_W-1:0] act,
                                               input logic [SLOT_W-1:0]   slot,
                                               input logic [TICK_W-1:0]   dly,
                                               input logic [TICK_W-1:0]   rld);
        timer_result_t     res;
        logic [TICK_W-1:0] elapsed;
        logic [TICK_W-1:0] spent_delay;
        bit                in_range;
        int                n;
        in_range = (slot < NUM_SLOTS);
        n = 0;
        case (act)
            ACT_REGISTER: begin
                if (in_range) begin
                    slot_start[slot] = tick_now;
                    if (!slot_registered[slot]) begin
                        slot_registered[slot] = 1'b1;
                        slot_enabled[slot] = 1'b0;
                    end
                end
            end
            ACT_SET: begin
                res.slot = slot;
                res.last = 1'b1;
                if (in_range && slot_registered[slot]) begin
                    slot_delay[slot] = dly;
                    slot_reload[slot] = rld;
                    values_written[slot] = 1'b1;
                    res.kind = KIND_SET_OK;
                end else begin
                    res.kind = KIND_SET_FAIL;
                end
                awaited_results.push_back(res);
            end
            ACT_START: if (in_range) slot_enabled[slot] = 1'b1;
            ACT_STOP:  if (in_range) slot_enabled[slot] = 1'b0;
            ACT_UNREG: if (in_range) slot_registered[slot] = 1'b0;
            ACT_TICK:  tick_now = tick_now + TICK_W'(step_now);
            ACT_SCAN: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (slot_registered[i] && slot_enabled[i]) begin
                        elapsed = tick_now - slot_start[i];
                        if (elapsed >= slot_delay[i]) begin
                            spent_delay = slot_delay[i];
                            if (slot_reload[i] == '0) begin
                                slot_enabled[i] = 1'b0;
                            end else begin
                                slot_start[i] = tick_now;
                                slot_delay[i] = slot_reload[i];
                            end
                            if (spent_delay != '0 && n < MAX_EXPIRIES) begin
                                res.slot = SLOT_W'(i);
                                res.kind = KIND_EXPIRY;
                                res.last = 1'b0;
                                awaited_results.push_back(res);
                                n++;
                            end
                        end
                    end
                end
                if (n > 0) awaited_results[$].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic logic [TICK_W-1:0] pick_delay();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8) return $urandom;
        if (r < 18) return '0;
        return $urandom_range(1, 4 * step_now + 1);
    endfunction

    function automatic logic [TICK_W-1:0] pick_reload();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30) return '0;
        if (r < 38) return $urandom;
        return $urandom_range(1, 3 * step_now + 1);
    endfunction

    task automatic send_item(input logic [ACTION_W-1:0] act,
                             input logic [SLOT_W-1:0]   slot,
                             input logic [TICK_W-1:0]   dly,
                             input logic [TICK_W-1:0]   rld);
        int idle;
        // a registered slot may only run once its delay and reload exist
        if (act == ACT_START && slot_registered[slot] && !values_written[slot]) begin
            act = ACT_SET;
            dly = pick_delay();
            rld = pick_reload();
        end
        idle = 0;
        while (idle < 8 && $urandom_range(99) < sender_idle_pct) idle++;
        repeat (idle) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= S_TDATA_W'({rld, dly, slot});
        do @(posedge aclk); while (s_tready !== 1'b1);
        sent_count++;
        apply_timer_action(act, slot, dly, rld);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_tick_step(input logic [STEP_W-1:0] value);
        wait_idle();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TICK_STEP;
        pwdata  <= APB_DATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        step_now = value;
        // read back
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (prdata !== APB_DATA_W'(value)) begin
            flag_failure($sformatf("tick_step readback: expected %0d, got %0h", value, prdata));
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_random_traffic(input int count);
        int                  sent;
        int                  ticks;
        int unsigned         pick;
        logic [SLOT_W-1:0]   slot;
        logic [ACTION_W-1:0] act;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
            if (pick < 30) begin
                send_item(ACT_REGISTER, slot, $urandom, $urandom);
                send_item(ACT_SET, slot, pick_delay(), pick_reload());
                send_item(ACT_START, slot, $urandom, $urandom);
                sent += 3;
            end else if (pick < 75) begin
                ticks = $urandom_range(1, 4);
                repeat (ticks) send_item(ACT_TICK, slot, $urandom, $urandom);
                send_item(ACT_SCAN, slot, $urandom, $urandom);
                sent += ticks + 1;
            end else begin
                act = ($urandom_range(19) == 0) ? ACT_UNDEFINED
                                                : ACTION_W'($urandom_range(0, 6));
                send_item(act, slot, $urandom, $urandom);
                if (act != ACT_UNDEFINED) sent++;
            end
        end
    endtask

    task automatic test_directed_actions();
        send_item(ACT_SET, 4'd3, 32'd5, 32'd0);
        send_item(ACT_REGISTER, 4'd3, '0, '0);
        send_item(ACT_SET, 4'd3, 32'd2, 32'd0);
        send_item(ACT_START, 4'd3, '0, '0);
        send_item(ACT_SCAN, 4'd0, '0, '0);
        send_item(ACT_TICK, 4'd0, '0, '0);
        send_item(ACT_TICK, 4'd0, '0, '0);
        send_item(ACT_SCAN, 4'd0, '0, '0);
        send_item(ACT_SCAN, 4'd0, '0, '0);
        send_item(ACT_REGISTER, 4'd15, '0, '0);
        send_item(ACT_SET, 4'd15, 32'd0, 32'd1);
        send_item(ACT_START, 4'd15, '0, '0);
        send_item(ACT_REGISTER, 4'd0, '0, '0);
        send_item(ACT_SET, 4'd0, '1, '1);
        send_item(ACT_START, 4'd0, '0, '0);
        send_item(ACT_SCAN, 4'd0, '0, '0);
        send_item(ACT_TICK, 4'd0, '0, '0);
        send_item(ACT_SCAN, 4'd0, '0, '0);
        send_item(ACT_STOP, 4'd0, '0, '0);
        send_item(ACT_REGISTER, 4'd0, '0, '0);
        send_item(ACT_UNREG, 4'd15, '0, '0);
        send_item(ACT_SCAN, 4'd0, '0, '0);
        send_item(ACT_START, 4'd7, '0, '0);
        send_item(ACT_REGISTER, 4'd7, '0, '0);
        send_item(ACT_UNDEFINED, 4'd9, $urandom, $urandom);
        send_item(ACT_SET, 4'd7, 32'd0, 32'd0);
        send_item(ACT_START, 4'd7, '0, '0);
        send_item(ACT_SCAN, 4'd0, '0, '0);
        wait_idle();
    endtask

    task automatic test_step_extremes();
        // zero step must leave the counter alone
        write_tick_step('0);
        send_item(ACT_REGISTER, 4'd9, '0, '0);
        send_item(ACT_SET, 4'd9, 32'd1, 32'd0);
        send_item(ACT_START, 4'd9, '0, '0);
        send_item(ACT_TICK, 4'd0, '0, '0);
        send_item(ACT_SCAN, 4'd0, '0, '0);
        write_tick_step('1);
        send_item(ACT_TICK, 4'd0, '0, '0);
        send_item(ACT_SCAN, 4'd0, '0, '0);
        wait_idle();
    endtask

    task automatic test_random_phase(input logic [STEP_W-1:0] step, input int send_pct,
                                     input int recv_pct, input int count);
        write_tick_step(step);
        sender_idle_pct = send_pct;
        receiver_stall_pct = recv_pct;
        send_random_traffic(count);
        wait_idle();
    endtask

    task automatic test_output_hold();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            send_item(ACT_REGISTER, SLOT_W'(i), '0, '0);
            send_item(ACT_SET, SLOT_W'(i), TICK_W'(step_now), TICK_W'(step_now));
            send_item(ACT_START, SLOT_W'(i), '0, '0);
        end
        send_item(ACT_TICK, 4'd0, '0, '0);
        hold_cycles = HOLD_CYCLES;
        repeat (3) begin
            send_item(ACT_SCAN, 4'd0, '0, '0);
            send_item(ACT_TICK, 4'd0, '0, '0);
        end
        wait_idle();
    endtask

    initial begin : result_sink
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        timer_result_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            result_count++;
            if (awaited_results.size() == 0) begin
                flag_failure($sformatf("unexpected result: tdata %02h kind %0d last %0b",
                                       m_tdata, m_tuser, m_tlast));
            end else begin
                want = awaited_results.pop_front();
                if (m_tdata !== M_TDATA_W'(want.slot) || m_tuser !== want.kind ||
                    m_tlast !== want.last) begin
                    flag_failure($sformatf(
                        "expected slot %0d kind %0d last %0b, got tdata %02h kind %0d last %0b",
                        want.slot, want.kind, want.last, m_tdata, m_tuser, m_tlast));
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet = 0;
            else quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        step_now = STEP_RESET;
        tick_now = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_registered[i] = 1'b0;
            slot_enabled[i]    = 1'b0;
            values_written[i]  = 1'b0;
            slot_start[i]      = '0;
            slot_delay[i]      = '0;
            slot_reload[i]     = '0;
        end
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_actions();
        test_step_extremes();
        test_random_phase(STEP_W'(1), 0, 0, 100);
        test_random_phase(STEP_W'(1000), 52, 0, 100);
        test_random_phase(STEP_W'($urandom_range(1, 1000)), 0, 52, 100);
        test_random_phase(STEP_W'(1), 38, 38, 100);
        test_output_hold();

        $display("sent %0d input transactions, checked %0d result transactions",
                 sent_count, result_count);
        $display("covered every action, tick_step 0/1/1000/1023/random, four idle mixes",
                 " and a long result-side hold");
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: soft_timer_bank.f
+incdir+rtl
rtl/stb_pkg.sv
rtl/stb_ctrl.sv
rtl/stb_dp.sv
rtl/soft_timer_bank.sv
tb/soft_timer_bank_tb.sv
